### src/knrb_pkg.sv
// Shared types and constants for the key matrix NKRO report builder.
package knrb_pkg;

	localparam int DEF_COLUMNS      = 14;
	localparam int DEF_ROWS         = 5;
	localparam int DEF_REPORT_BYTES = 22;

	// Upper bound of the ROWS parameter; sizes the row lanes of a queue entry.
	localparam int MAX_ROWS = 8;

	// Entries of the queue between front and back.
	localparam int QDEPTH = 4;

	localparam logic [7:0] MOD_FIRST = 8'hE0;
	localparam logic [7:0] MOD_LAST  = 8'hE7;
	localparam logic [7:0] MOD_MASK  = 8'h07;

	typedef enum logic [1:0] {
		ACT_SCAN  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} act_t;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] column;
		logic [4:0] row_bits;
		logic [2:0] row;
		logic [7:0] keycode;
		logic [4:0] byte_index;
	} in_item_t;

	typedef struct packed {
		logic       changed;
		logic [7:0] read_data;
	} out_item_t;

	// Classified work handed from front to back.
	typedef struct packed {
		logic                          scan;
		logic                          rd;
		logic [MAX_ROWS-1:0]           press;
		logic [MAX_ROWS-1:0][7:0]      codes;
		logic [4:0]                    byte_index;
	} fe_item_t;

endpackage

### src/knrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module knrb_ram import knrb_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = DEF_COLUMNS
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/knrb_front.sv
// Front end: accepts items, writes the key table, fetches a column's keycodes.
module knrb_front import knrb_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	output logic     q_wr,
	output fe_item_t q_wdata,
	input  logic     q_full
);

	localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	logic                     accept;
	logic                     col_ok;
	logic                     row_ok;
	logic [CW-1:0]            addr;
	logic [MAX_ROWS-1:0]      row_mask;
	logic [MAX_ROWS-1:0][7:0] codes;

	logic                valid_s1;
	logic                scan_s1;
	logic                rd_s1;
	logic [MAX_ROWS-1:0] press_s1;
	logic [4:0]          bidx_s1;

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign col_ok = 32'(item.column) < 32'(COLUMNS);
	assign row_ok = 32'(item.row) < 32'(ROWS);
	assign addr   = CW'(item.column);

	always_comb begin
		for (int r = 0; r < MAX_ROWS; r++) begin
			row_mask[r] = (r < ROWS);
		end
	end

	// One bank per row so a scan fetches the whole column in one read.
	for (genvar r = 0; r < MAX_ROWS; r++) begin : g_bank
		if (r < ROWS) begin : g_used
			knrb_ram #(
				.WIDTH(8),
				.DEPTH(COLUMNS)
			) u_ram (
				.clk  (clk),
				.we   (accept && item.action == ACT_WRITE && col_ok && row_ok
				       && item.row == 3'(r)),
				.waddr(addr),
				.wdata(item.keycode),
				.re   (accept && item.action == ACT_SCAN),
				.raddr(addr),
				.rdata(codes[r])
			);
		end else begin : g_unused
			assign codes[r] = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scan_s1  <= (item.action == ACT_SCAN) && col_ok;
			rd_s1    <= (item.action == ACT_READ);
			press_s1 <= MAX_ROWS'(item.row_bits) & row_mask;
			bidx_s1  <= item.byte_index;
		end
	end

	assign q_wr               = valid_s1 && !q_full;
	assign q_wdata.scan       = scan_s1;
	assign q_wdata.rd         = rd_s1;
	assign q_wdata.press      = press_s1;
	assign q_wdata.codes      = codes;
	assign q_wdata.byte_index = bidx_s1;

endmodule

### src/knrb_fifo.sv
// Short queue that decouples the front end from the report back end.
module knrb_fifo import knrb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  fe_item_t wdata,
	output logic     full,
	input  logic     rd,
	output fe_item_t rdata,
	output logic     nempty
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNW = $clog2(QDEPTH + 1);

	fe_item_t       mem_q [QDEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [CNW-1:0] cnt_q;

	assign full   = cnt_q == CNW'(QDEPTH);
	assign nempty = cnt_q != '0;
	assign rdata  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### src/knrb_back.sv
// Back end: applies column scans to the report bitmap and serves byte reads.
module knrb_back import knrb_pkg::*; #(
	parameter int ROWS         = DEF_ROWS,
	parameter int REPORT_BYTES = DEF_REPORT_BYTES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_nempty,
	input  fe_item_t  q_rdata,
	output logic      q_rd,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	localparam int RBITS = REPORT_BYTES * 8;
	localparam int RPW   = $clog2(RBITS);

	logic [RBITS-1:0] report_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [RBITS-1:0] next_report;
	logic             chg;
	logic [7:0]       rd_byte;
	logic [7:0]       code;
	logic [5:0]       byte_sel;
	logic [8:0]       pos;
	logic             take;

	assign take = q_nempty && (!out_valid_q || pop);
	assign q_rd = take;

	// Apply rows in order; a later row sees what an earlier one left.
	always_comb begin
		next_report = report_q;
		chg         = 1'b0;
		code        = 8'h00;
		byte_sel    = 6'd0;
		pos         = 9'd0;
		for (int r = 0; r < ROWS; r++) begin
			code = q_rdata.codes[r];
			if (code >= MOD_FIRST && code <= MOD_LAST) begin
				byte_sel = 6'd0;
			end else begin
				byte_sel = 6'(code[7:3]) + 6'd1;
			end
			pos = {byte_sel, 3'(code & MOD_MASK)};
			if (32'(byte_sel) < 32'(REPORT_BYTES)) begin
				if (next_report[pos[RPW-1:0]] != q_rdata.press[r]) begin
					chg = 1'b1;
				end
				next_report[pos[RPW-1:0]] = q_rdata.press[r];
			end
		end
	end

	always_comb begin
		rd_byte = 8'h00;
		for (int b = 0; b < REPORT_BYTES; b++) begin
			if (6'(q_rdata.byte_index) == 6'(b)) begin
				rd_byte = report_q[b*8 +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= take || (out_valid_q && !pop);
			if (take && q_rdata.scan) begin
				report_q <= next_report;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.changed   <= q_rdata.scan && chg;
			out_q.read_data <= q_rdata.rd ? rd_byte : 8'h00;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

### src/key_matrix_nkro_report_builder.sv
// Top level of the key matrix NKRO report builder.
//
// Usage: items enter through a queue-style port. Drive item and raise push;
// a transfer happens on a clock edge with push high and full low. Actions:
// scan a column (row_bits against the key table), write one key table
// entry, or read one report byte. Every item yields exactly one result.
// Results leave the same way: while empty is low, result holds the oldest
// one; a transfer happens on an edge with pop high and empty low.
// Path: front stage register, middle queue, output register.
// Throughput: one item per cycle, sustained, as long as results are taken.
// The front end fetches a whole column of keycodes in one read from one
// RAM bank per row; the back end applies all rows of a column to the
// report bitmap combinationally, so neither side limits the rate below one.
// Reset clears the report bitmap and all queues; the key table is not
// cleared and must be loaded before any scan of a column.
// When the receiver stalls, the output register holds, the middle queue
// fills, then the front stage holds and full rises; nothing is dropped.
module key_matrix_nkro_report_builder import knrb_pkg::*; #(
	parameter int COLUMNS      = DEF_COLUMNS,
	parameter int ROWS         = DEF_ROWS,
	parameter int REPORT_BYTES = DEF_REPORT_BYTES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	// Front to queue, queue to back.
	logic     q_wr;
	fe_item_t q_wdata;
	logic     q_full;
	logic     q_rd;
	fe_item_t q_rdata;
	logic     q_nempty;

	// Classify the item and fetch its column's keycodes.
	knrb_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_wr   (q_wr),
		.q_wdata(q_wdata),
		.q_full (q_full)
	);

	// Hold classified work so either side can stall on its own.
	knrb_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_wr),
		.wdata (q_wdata),
		.full  (q_full),
		.rd    (q_rd),
		.rdata (q_rdata),
		.nempty(q_nempty)
	);

	// Update the report and present results.
	knrb_back #(
		.ROWS        (ROWS),
		.REPORT_BYTES(REPORT_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_nempty(q_nempty),
		.q_rdata (q_rdata),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

### src/knrb_checker.sv
// Port-level checks for the key matrix NKRO report builder, bound to the top.
module knrb_checker import knrb_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      push,
	input logic      full,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	// Items accepted but not yet popped; at most front stage, queue and output.
	localparam int MAX_OUT = QDEPTH + 2;

	logic [3:0] outstanding_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = push && !full;
	assign out_xfer = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			case ({in_xfer, out_xfer})
				2'b10:   outstanding_q <= outstanding_q + 1'b1;
				2'b01:   outstanding_q <= outstanding_q - 1'b1;
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed before transfer");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q == 4'd0 |-> empty)
		else $error("result shown with no item outstanding");

	a_full_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> outstanding_q != 4'd0)
		else $error("full raised with nothing in flight");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(outstanding_q) <= MAX_OUT)
		else $error("more items in flight than storage allows");

endmodule

bind key_matrix_nkro_report_builder knrb_checker u_knrb_checker (.*);

### test/key_matrix_nkro_report_builder_tb.sv
// Testbench for the key matrix NKRO report builder: directed and random traffic, self-checked.
module key_matrix_nkro_report_builder_tb;
	import knrb_pkg::*;

	localparam int N_COLS  = DEF_COLUMNS;
	localparam int N_ROWS  = DEF_ROWS;
	localparam int N_BYTES = DEF_REPORT_BYTES;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      full;
	in_item_t  item   = '0;
	logic      empty;
	logic      pop    = 1'b0;
	out_item_t result;

	// Mirror of the block state: key table with a loaded flag per entry, and the report bitmap.
	logic [7:0] key_map    [N_COLS*N_ROWS];
	bit         key_loaded [N_COLS*N_ROWS];
	logic [7:0] report_img [N_BYTES];

	// Answers owed by the block, oldest first.
	out_item_t  pending_answers [$];
	int         error_count = 0;

	// Traffic shaping knobs, in percent per cycle.
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;
	// Set while the receiver is forced to hold off.
	logic       recv_hold = 1'b0;

	key_matrix_nkro_report_builder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Drive one key to a level in the report mirror; return 1 if a bit flipped.
	function automatic bit drive_report_bit(input logic [7:0] code, input bit down);
		int         idx;
		int         pos;
		logic [7:0] old_val;
		if (code >= MOD_FIRST && code <= MOD_LAST) begin
			idx = 0;
			pos = int'(code & MOD_MASK);
		end else begin
			idx = int'(code) / 8 + 1;
			pos = int'(code) % 8;
		end
		// Keycodes that land past the last report byte do nothing.
		if (idx >= N_BYTES)
			return 1'b0;
		old_val = report_img[idx];
		report_img[idx][pos] = down;
		return report_img[idx] != old_val;
	endfunction

	// Advance the mirror by one accepted item and return the answer it owes.
	function automatic out_item_t apply_to_report(input in_item_t it);
		out_item_t ans;
		int        base;
		ans  = '0;
		base = int'(it.column) * N_ROWS;
		case (act_t'(it.action))
			ACT_SCAN: begin
				// Rows go in order, so a later row sees what an earlier row left.
				if (it.column < N_COLS)
					for (int r = 0; r < N_ROWS; r++)
						if (drive_report_bit(key_map[base + r], it.row_bits[r]))
							ans.changed = 1'b1;
			end
			ACT_WRITE: begin
				if (it.column < N_COLS && it.row < N_ROWS) begin
					key_map[base + int'(it.row)]    = it.keycode;
					key_loaded[base + int'(it.row)] = 1'b1;
				end
			end
			ACT_READ: begin
				if (it.byte_index < N_BYTES)
					ans.read_data = report_img[it.byte_index];
			end
			default: ;
		endcase
		return ans;
	endfunction

	// A column may be scanned only once every row of it holds a keycode.
	function automatic bit column_ready(input int c);
		for (int r = 0; r < N_ROWS; r++)
			if (!key_loaded[c*N_ROWS + r])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic in_item_t make_item(input act_t act, input int col, input int rbits,
			input int rw, input int code, input int bidx);
		in_item_t it;
		it.action     = act;
		it.column     = col[3:0];
		it.row_bits   = rbits[4:0];
		it.row        = rw[2:0];
		it.keycode    = code[7:0];
		it.byte_index = bidx[4:0];
		return it;
	endfunction

	// Favor modifiers and low codes so keys collide on report bits and toggle often.
	function automatic logic [7:0] random_keycode();
		int pick;
		pick = $urandom_range(99);
		if (pick < 35)
			return MOD_FIRST + 8'($urandom_range(7));
		else if (pick < 70)
			return 8'($urandom_range(31));
		else
			return 8'($urandom_range(255));
	endfunction

	// Mostly well-formed traffic: writes, scans of loaded columns, reads; some noise.
	function automatic in_item_t random_item();
		in_item_t it;
		int       pick;
		int       ready_cols [$];
		it.action     = ACT_NONE;
		it.column     = 4'($urandom_range(15));
		it.row_bits   = 5'($urandom_range(31));
		it.row        = 3'($urandom_range(7));
		it.keycode    = random_keycode();
		it.byte_index = 5'($urandom_range(31));
		pick = $urandom_range(99);
		if (pick < 12) begin
			it.action = ACT_WRITE;
			if ($urandom_range(99) < 85)
				it.column = 4'($urandom_range(N_COLS - 1));
			if ($urandom_range(99) < 85)
				it.row = 3'($urandom_range(N_ROWS - 1));
		end else if (pick < 65) begin
			it.action = ACT_SCAN;
			for (int c = 0; c < N_COLS; c++)
				if (column_ready(c))
					ready_cols.push_back(c);
			// Scan a loaded column, or now and then one past the matrix.
			if (ready_cols.size() != 0 && $urandom_range(9) != 0)
				it.column = 4'(ready_cols[$urandom_range(ready_cols.size() - 1)]);
			else
				it.column = 4'(N_COLS + $urandom_range(15 - N_COLS));
		end else if (pick < 95) begin
			it.action = ACT_READ;
			if ($urandom_range(99) < 85)
				it.byte_index = 5'($urandom_range(N_BYTES - 1));
		end
		return it;
	endfunction

	// Offer one item, with a random idle gap first; return at the edge of its transfer.
	// Push stays high on return so back-to-back items need no gap.
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pending_answers.push_back(apply_to_report(it));
	endtask

	// Drop push, wait until every owed answer came back, then let the pipeline settle.
	task automatic wait_for_answers();
		push <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_answer(input out_item_t got);
		out_item_t want;
		if (pending_answers.size() == 0) begin
			$error("unexpected result: changed %0d read_data 0x%02h", got.changed, got.read_data);
			error_count++;
			return;
		end
		want = pending_answers.pop_front();
		if (got.changed !== want.changed) begin
			$error("changed: expected %0d, got %0d", want.changed, got.changed);
			error_count++;
		end
		if (got.read_data !== want.read_data) begin
			$error("read_data: expected 0x%02h, got 0x%02h", want.read_data, got.read_data);
			error_count++;
		end
	endtask

	// Result side: check each transfer, then decide the next cycle's pop.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				check_answer(result);
			if (recv_hold)
				pop <= 1'b0;
			else
				pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Load two full columns: column 0 and the last column, plus writes that must be dropped.
	task automatic test_table_load();
		// Column 0: both modifier ends, keycode zero, and the same key on two rows.
		send_item(make_item(ACT_WRITE, 0, 0, 0, 'hE0, 0));
		send_item(make_item(ACT_WRITE, 0, 0, 1, 'hE7, 0));
		send_item(make_item(ACT_WRITE, 0, 0, 2, 'h00, 0));
		send_item(make_item(ACT_WRITE, 0, 0, 3, 'h04, 0));
		send_item(make_item(ACT_WRITE, 0, 0, 4, 'h04, 0));
		// Last column: codes past the report, the last report bit, a modifier.
		send_item(make_item(ACT_WRITE, N_COLS - 1, 0, 0, 'hFF, 0));
		send_item(make_item(ACT_WRITE, N_COLS - 1, 0, 1, 'hA7, 0));
		send_item(make_item(ACT_WRITE, N_COLS - 1, 0, 2, 'hA8, 0));
		send_item(make_item(ACT_WRITE, N_COLS - 1, 0, 3, 'hE3, 0));
		send_item(make_item(ACT_WRITE, N_COLS - 1, 0, 4, 'h07, 0));
		// Row past the matrix and column past the matrix: both ignored.
		send_item(make_item(ACT_WRITE, 0, 0, 7, 'hFF, 0));
		send_item(make_item(ACT_WRITE, 15, 31, 0, 'h55, 31));
		wait_for_answers();
	endtask

	task automatic test_scan_edges();
		send_item(make_item(ACT_SCAN, 0, 31, 0, 0, 0));
		// Row 3 presses the key that row 4 then releases.
		send_item(make_item(ACT_SCAN, 0, 5'b01000, 0, 0, 0));
		send_item(make_item(ACT_SCAN, 0, 0, 7, 255, 31));
		send_item(make_item(ACT_SCAN, N_COLS - 1, 31, 0, 0, 0));
		send_item(make_item(ACT_SCAN, N_COLS - 1, 5'b01010, 0, 0, 0));
		// Columns past the matrix: no effect, no change.
		send_item(make_item(ACT_SCAN, 15, 31, 7, 255, 31));
		send_item(make_item(ACT_SCAN, N_COLS, 31, 0, 0, 0));
		wait_for_answers();
	endtask

	task automatic test_reads_and_unused();
		send_item(make_item(ACT_READ, 0, 0, 0, 0, 0));
		send_item(make_item(ACT_READ, 15, 31, 7, 255, 1));
		send_item(make_item(ACT_READ, 0, 0, 0, 0, N_BYTES - 1));
		// Reads past the report answer zero.
		send_item(make_item(ACT_READ, 0, 0, 0, 0, N_BYTES));
		send_item(make_item(ACT_READ, 0, 0, 0, 0, 31));
		// Unused action with every field at its top.
		send_item(make_item(ACT_NONE, 15, 31, 7, 255, 31));
		wait_for_answers();
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_item(random_item());
		wait_for_answers();
	endtask

	// Hold the receiver off for a long stretch while items keep coming, so full rises.
	task automatic test_backpressure(input int count, input int hold_cycles);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		fork
			begin
				recv_hold <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				recv_hold <= 1'b0;
			end
			begin
				repeat (count)
					send_item(random_item());
			end
		join
		wait_for_answers();
	endtask

	initial begin
		for (int i = 0; i < N_COLS*N_ROWS; i++) begin
			key_map[i]    = '0;
			key_loaded[i] = 1'b0;
		end
		for (int i = 0; i < N_BYTES; i++)
			report_img[i] = '0;

		// Hold reset, then release it on an edge.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_load();
		test_scan_edges();
		test_reads_and_unused();
		test_random_traffic(450, 0, 0);
		test_random_traffic(450, 81, 0);
		test_random_traffic(450, 0, 81);
		test_random_traffic(450, 15, 15);
		test_backpressure(60, 300);

		if (error_count == 0 && pending_answers.size() == 0)
			$display("key_matrix_nkro_report_builder_tb: done, clean");
		else
			$display("key_matrix_nkro_report_builder_tb: done, errors");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("key_matrix_nkro_report_builder_tb: done, errors");
		$finish;
	end

endmodule
